>>> rtl/pnps_pkg.sv
// ----------------------------------------------------------------------------
// pnps_pkg
// Shared types and constants of the polyline nearest point search block.
// ----------------------------------------------------------------------------
package pnps_pkg;

    localparam int CRDW      = 32;
    localparam int DIFW      = 33;
    localparam int MOPW      = 34;
    localparam int PRDW      = 68;
    localparam int ACCW      = 104;
    localparam int NUMW      = 67;
    localparam int DENW      = 65;
    localparam int QW        = 33;
    localparam int DIV_NW    = 99;
    localparam int DIV_DW    = 66;
    localparam int SQ_RW     = 102;
    localparam int SQ_ROOTW  = 51;
    localparam int SQ_REMW   = 53;
    localparam int SQ_DIST_N = 33;
    localparam int SQ_MET_N  = 51;
    localparam int DISTW     = 34;
    localparam int OUTDW     = 50;
    localparam int MAGW      = 50;
    localparam int HALFW     = 25;
    localparam int SEGW      = 10;
    localparam int CFGW      = 17;
    localparam int CFG_IDXW  = 2;

    localparam logic [CFG_IDXW-1:0] REG_DISTANCE_MODE = 2'd0;
    localparam logic [CFG_IDXW-1:0] REG_LON_SCALE     = 2'd1;
    localparam logic [CFG_IDXW-1:0] REG_LAT_SCALE     = 2'd2;

    localparam logic [CFGW-1:0] LON_SCALE_RST = 17'd102000;
    localparam logic [CFGW-1:0] LAT_SCALE_RST = 17'd111000;

    typedef enum logic [4:0] {
        MS_NONE,
        MS_DX_VX,
        MS_DY_VY,
        MS_VX_VX,
        MS_VY_VY,
        MS_DX_DX,
        MS_DY_DY,
        MS_FX_FX,
        MS_FY_FY,
        MS_NLO_VX,
        MS_NHI_VX,
        MS_NLO_VY,
        MS_NHI_VY,
        MS_EX_EX,
        MS_EY_EY,
        MS_EX_LON,
        MS_EY_LAT,
        MS_MXL_MXL,
        MS_MXL_MXH,
        MS_MXH_MXH,
        MS_MYL_MYL,
        MS_MYL_MYH,
        MS_MYH_MYH
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef enum logic [1:0] {
        SH_0,
        SH_26,
        SH_33,
        SH_50
    } acc_sh_t;

    typedef struct packed {
        logic     load;
        logic     sat_count;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        acc_sh_t  acc_sh;
        logic     store_num;
        logic     store_den;
        logic     store_da;
        logic     endpoint;
        logic     div_start;
        logic     set_ox;
        logic     set_oy;
        logic     diff_e;
        logic     diff_best;
        logic     store_mx;
        logic     store_my;
        logic     sqrt_start;
        logic     sqrt_metric;
        logic     update;
        logic     emit;
    } dp_cmd_t;

    typedef struct packed {
        logic last;
        logic stopped;
        logic ctr_full;
        logic proj;
        logic div_done;
        logic sqrt_done;
        logic out_busy;
        logic mode;
    } dp_stat_t;

endpackage

>>> rtl/pnps_div.sv
// ----------------------------------------------------------------------------
// pnps_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pnps_div
    import pnps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_NW-1:0] num,
    input  logic [DIV_DW-1:0] den,
    output logic              done,
    output logic [QW-1:0]     quo
);

    localparam int CNTW = $clog2(QW + 1);

    logic [DIV_DW-1:0] rem_reg, rem_next;
    logic [DIV_DW-1:0] den_reg;
    logic [QW-1:0]     low_reg;
    logic [QW-1:0]     quo_reg;
    logic [CNTW-1:0]   cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIV_DW:0]   trial;
    logic [DIV_DW:0]   diff;
    logic              ge;

    always_comb
    begin
        trial    = {rem_reg, low_reg[QW-1]};
        diff     = trial - {1'b0, den_reg};
        ge       = trial >= {1'b0, den_reg};
        rem_next = ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(QW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num[DIV_NW-1:QW];
            low_reg <= num[QW-1:0];
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            low_reg <= {low_reg[QW-2:0], 1'b0};
            quo_reg <= {quo_reg[QW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

>>> rtl/pnps_sqrt.sv
// ----------------------------------------------------------------------------
// pnps_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module pnps_sqrt
    import pnps_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                metric,
    input  logic [SQ_RW-1:0]    rad,
    output logic                done,
    output logic [SQ_ROOTW-1:0] root
);

    localparam int CNTW = $clog2(SQ_MET_N + 1);

    logic [SQ_RW-1:0]    op_reg;
    logic [SQ_REMW-1:0]  rem_reg, rem_next;
    logic [SQ_ROOTW-1:0] root_reg, root_next;
    logic [CNTW-1:0]     cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic [SQ_REMW+1:0]  cur;
    logic [SQ_REMW+1:0]  trial;
    logic [SQ_REMW+1:0]  diff;
    logic                ge;

    always_comb
    begin
        cur       = {rem_reg, op_reg[SQ_RW-1:SQ_RW-2]};
        trial     = (SQ_REMW+2)'({root_reg, 2'b01});
        diff      = cur - trial;
        ge        = cur >= trial;
        rem_next  = ge ? diff[SQ_REMW-1:0] : cur[SQ_REMW-1:0];
        root_next = {root_reg[SQ_ROOTW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= metric ? CNTW'(SQ_MET_N) : CNTW'(SQ_DIST_N);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg   <= rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            op_reg   <= {op_reg[SQ_RW-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

>>> rtl/pnps_datapath.sv
// ----------------------------------------------------------------------------
// pnps_datapath
// Operand registers, shared multiplier and accumulator, divider, square
// root, search state, configuration registers and result register.
// ----------------------------------------------------------------------------
module pnps_datapath
    import pnps_pkg::*;
#(
    parameter int MAX_SEGMENTS = 1024
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic signed [31:0]   query_x,
    input  logic signed [31:0]   query_y,
    input  logic signed [31:0]   seg_start_x,
    input  logic signed [31:0]   seg_start_y,
    input  logic signed [31:0]   seg_end_x,
    input  logic signed [31:0]   seg_end_y,
    input  logic                 first_segment,
    input  logic                 last_segment,
    input  logic                 cfg_valid,
    input  logic [CFG_IDXW-1:0]  cfg_index,
    input  logic [CFGW-1:0]      cfg_data,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [SEGW-1:0]      nearest_segment,
    output logic signed [31:0]   near_x,
    output logic signed [31:0]   near_y,
    output logic [OUTDW-1:0]     distance,
    output logic                 overflow
);

    localparam int CTRW = $clog2(MAX_SEGMENTS + 2);
    localparam int IDXW = $clog2(MAX_SEGMENTS);

    logic                    mode_reg;
    logic [CFGW-1:0]         lon_reg;
    logic [CFGW-1:0]         lat_reg;

    logic signed [CRDW-1:0]  qx_reg, qy_reg, ax_reg, ay_reg, bx_reg, by_reg;
    logic                    last_reg;
    logic signed [DIFW-1:0]  vx_reg, vy_reg, dx_reg, dy_reg, fx_reg, fy_reg;
    logic signed [DIFW-1:0]  ex_reg, ey_reg;
    logic [DIFW-1:0]         avx, avy;

    logic signed [MOPW-1:0]  ma, mb;
    logic signed [PRDW-1:0]  prod_reg;
    logic [PRDW-1:0]         prod_abs;
    logic signed [ACCW-1:0]  prod_ext, addend;
    logic signed [ACCW-1:0]  acc_reg;

    logic signed [NUMW-1:0]  num_reg;
    logic [DENW-1:0]         den_reg;
    logic [DENW-1:0]         da_reg;
    logic [DENW-1:0]         db;
    logic [MAGW-1:0]         mx_reg, my_reg;

    logic signed [CRDW-1:0]  ox_reg, oy_reg;
    logic [CRDW+1:0]         ox_sum, oy_sum;

    logic [DIV_NW-1:0]       div_num;
    logic [DIV_DW-1:0]       div_den;
    logic                    div_done;
    logic [QW-1:0]           div_quo;

    logic [SQ_RW-1:0]        sq_rad;
    logic                    sq_done;
    logic [SQ_ROOTW-1:0]     sq_root;
    logic [DISTW-1:0]        seg_dist;
    logic [OUTDW-1:0]        metric_sat;

    logic [DISTW-1:0]        best_dist_reg;
    logic [IDXW-1:0]         best_idx_reg;
    logic signed [CRDW-1:0]  best_x_reg, best_y_reg;
    logic [CTRW-1:0]         seg_cnt_reg;
    logic                    stopped_reg;

    logic                    out_valid_reg;
    logic [SEGW-1:0]         out_seg_reg;
    logic signed [CRDW-1:0]  out_x_reg, out_y_reg;
    logic [OUTDW-1:0]        out_dist_reg;
    logic                    out_ovf_reg;

    function automatic logic signed [DIFW-1:0] sx(input logic signed [CRDW-1:0] v);
        return {v[CRDW-1], v};
    endfunction

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            lon_reg  <= LON_SCALE_RST;
            lat_reg  <= LAT_SCALE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_DISTANCE_MODE: mode_reg <= cfg_data[0];
                REG_LON_SCALE:     lon_reg  <= cfg_data;
                REG_LAT_SCALE:     lat_reg  <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign avx = vx_reg[DIFW-1] ? DIFW'(-vx_reg) : vx_reg;
    assign avy = vy_reg[DIFW-1] ? DIFW'(-vy_reg) : vy_reg;

    // multiplier operand select
    always_comb
    begin
        case (cmd.mul_sel)
            MS_DX_VX:   begin ma = MOPW'(dx_reg); mb = MOPW'(vx_reg); end
            MS_DY_VY:   begin ma = MOPW'(dy_reg); mb = MOPW'(vy_reg); end
            MS_VX_VX:   begin ma = MOPW'(vx_reg); mb = MOPW'(vx_reg); end
            MS_VY_VY:   begin ma = MOPW'(vy_reg); mb = MOPW'(vy_reg); end
            MS_DX_DX:   begin ma = MOPW'(dx_reg); mb = MOPW'(dx_reg); end
            MS_DY_DY:   begin ma = MOPW'(dy_reg); mb = MOPW'(dy_reg); end
            MS_FX_FX:   begin ma = MOPW'(fx_reg); mb = MOPW'(fx_reg); end
            MS_FY_FY:   begin ma = MOPW'(fy_reg); mb = MOPW'(fy_reg); end
            MS_NLO_VX:  begin ma = {1'b0, num_reg[QW-1:0]};    mb = {1'b0, avx}; end
            MS_NHI_VX:  begin ma = {2'b00, num_reg[64:QW]};    mb = {1'b0, avx}; end
            MS_NLO_VY:  begin ma = {1'b0, num_reg[QW-1:0]};    mb = {1'b0, avy}; end
            MS_NHI_VY:  begin ma = {2'b00, num_reg[64:QW]};    mb = {1'b0, avy}; end
            MS_EX_EX:   begin ma = MOPW'(ex_reg); mb = MOPW'(ex_reg); end
            MS_EY_EY:   begin ma = MOPW'(ey_reg); mb = MOPW'(ey_reg); end
            MS_EX_LON:  begin ma = MOPW'(ex_reg); mb = {{(MOPW-CFGW){1'b0}}, lon_reg}; end
            MS_EY_LAT:  begin ma = MOPW'(ey_reg); mb = {{(MOPW-CFGW){1'b0}}, lat_reg}; end
            MS_MXL_MXL: begin
                ma = {{(MOPW-HALFW){1'b0}}, mx_reg[HALFW-1:0]};
                mb = {{(MOPW-HALFW){1'b0}}, mx_reg[HALFW-1:0]};
            end
            MS_MXL_MXH: begin
                ma = {{(MOPW-HALFW){1'b0}}, mx_reg[HALFW-1:0]};
                mb = {{(MOPW-HALFW){1'b0}}, mx_reg[MAGW-1:HALFW]};
            end
            MS_MXH_MXH: begin
                ma = {{(MOPW-HALFW){1'b0}}, mx_reg[MAGW-1:HALFW]};
                mb = {{(MOPW-HALFW){1'b0}}, mx_reg[MAGW-1:HALFW]};
            end
            MS_MYL_MYL: begin
                ma = {{(MOPW-HALFW){1'b0}}, my_reg[HALFW-1:0]};
                mb = {{(MOPW-HALFW){1'b0}}, my_reg[HALFW-1:0]};
            end
            MS_MYL_MYH: begin
                ma = {{(MOPW-HALFW){1'b0}}, my_reg[HALFW-1:0]};
                mb = {{(MOPW-HALFW){1'b0}}, my_reg[MAGW-1:HALFW]};
            end
            MS_MYH_MYH: begin
                ma = {{(MOPW-HALFW){1'b0}}, my_reg[MAGW-1:HALFW]};
                mb = {{(MOPW-HALFW){1'b0}}, my_reg[MAGW-1:HALFW]};
            end
            default:    begin ma = '0; mb = '0; end
        endcase
    end

    always_comb
    begin
        prod_ext = {{(ACCW-PRDW){prod_reg[PRDW-1]}}, prod_reg};
        case (cmd.acc_sh)
            SH_0:    addend = prod_ext;
            SH_26:   addend = prod_ext <<< 26;
            SH_33:   addend = prod_ext <<< 33;
            SH_50:   addend = prod_ext <<< 50;
            default: addend = prod_ext;
        endcase
        prod_abs = prod_reg[PRDW-1] ? PRDW'(-prod_reg) : prod_reg;
    end

    assign db      = acc_reg[DENW-1:0];
    assign div_num = DIV_NW'({acc_reg[96:0], 1'b0}) + DIV_NW'(den_reg);
    assign div_den = {den_reg, 1'b0};
    assign sq_rad  = cmd.sqrt_metric ? acc_reg[SQ_RW-1:0]
                                     : {acc_reg[DENW:0], {(SQ_RW-DENW-1){1'b0}}};
    assign ox_sum  = vx_reg[DIFW-1] ? (CRDW+2)'(ax_reg) - (CRDW+2)'(div_quo)
                                    : (CRDW+2)'(ax_reg) + (CRDW+2)'(div_quo);
    assign oy_sum  = vy_reg[DIFW-1] ? (CRDW+2)'(ay_reg) - (CRDW+2)'(div_quo)
                                    : (CRDW+2)'(ay_reg) + (CRDW+2)'(div_quo);
    assign seg_dist   = {1'b0, sq_root[DISTW-2:0]};
    assign metric_sat = sq_root[SQ_ROOTW-1] ? '1 : sq_root[OUTDW-1:0];

    // arithmetic payload
    always_ff @(posedge clk)
    begin
        prod_reg <= ma * mb;
        case (cmd.acc_op)
            ACC_LOAD: acc_reg <= addend;
            ACC_ADD:  acc_reg <= acc_reg + addend;
            default:  ;
        endcase
        if (cmd.load)
        begin
            qx_reg   <= query_x;
            qy_reg   <= query_y;
            ax_reg   <= seg_start_x;
            ay_reg   <= seg_start_y;
            bx_reg   <= seg_end_x;
            by_reg   <= seg_end_y;
            vx_reg   <= sx(seg_end_x) - sx(seg_start_x);
            vy_reg   <= sx(seg_end_y) - sx(seg_start_y);
            dx_reg   <= sx(query_x) - sx(seg_start_x);
            dy_reg   <= sx(query_y) - sx(seg_start_y);
            fx_reg   <= sx(query_x) - sx(seg_end_x);
            fy_reg   <= sx(query_y) - sx(seg_end_y);
        end
        if (cmd.store_num)
            num_reg <= acc_reg[NUMW-1:0];
        if (cmd.store_den)
            den_reg <= acc_reg[DENW-1:0];
        if (cmd.store_da)
            da_reg <= acc_reg[DENW-1:0];
        if (cmd.endpoint)
        begin
            ox_reg <= (da_reg < db) ? ax_reg : bx_reg;
            oy_reg <= (da_reg < db) ? ay_reg : by_reg;
        end
        if (cmd.set_ox)
            ox_reg <= ox_sum[CRDW-1:0];
        if (cmd.set_oy)
            oy_reg <= oy_sum[CRDW-1:0];
        if (cmd.diff_e)
        begin
            ex_reg <= sx(ox_reg) - sx(qx_reg);
            ey_reg <= sx(oy_reg) - sx(qy_reg);
        end
        if (cmd.diff_best)
        begin
            ex_reg <= sx(best_x_reg) - sx(qx_reg);
            ey_reg <= sx(best_y_reg) - sx(qy_reg);
        end
        if (cmd.store_mx)
            mx_reg <= prod_abs[MAGW-1:0];
        if (cmd.store_my)
            my_reg <= prod_abs[MAGW-1:0];
        if (cmd.emit)
        begin
            out_seg_reg  <= SEGW'(best_idx_reg);
            out_x_reg    <= best_x_reg;
            out_y_reg    <= best_y_reg;
            out_dist_reg <= mode_reg ? metric_sat : OUTDW'(best_dist_reg);
            out_ovf_reg  <= seg_cnt_reg > CTRW'(MAX_SEGMENTS);
        end
    end

    // search state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg      <= 1'b0;
            best_dist_reg <= '1;
            best_idx_reg  <= '0;
            best_x_reg    <= '0;
            best_y_reg    <= '0;
            seg_cnt_reg   <= '0;
            stopped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_ready && !cmd.emit)
                out_valid_reg <= 1'b0;
            if (cmd.load)
            begin
                last_reg <= last_segment;
                if (first_segment)
                begin
                    best_dist_reg <= '1;
                    seg_cnt_reg   <= '0;
                    stopped_reg   <= 1'b0;
                end
            end
            if (cmd.sat_count)
                seg_cnt_reg <= CTRW'(MAX_SEGMENTS + 1);
            if (cmd.update)
            begin
                seg_cnt_reg <= seg_cnt_reg + 1'b1;
                if (seg_cnt_reg == '0 || seg_dist <= best_dist_reg)
                begin
                    if (seg_cnt_reg != '0 && seg_dist == best_dist_reg)
                        stopped_reg <= 1'b1;
                    best_dist_reg <= seg_dist;
                    best_idx_reg  <= seg_cnt_reg[IDXW-1:0];
                    best_x_reg    <= ox_reg;
                    best_y_reg    <= oy_reg;
                end
                else
                begin
                    stopped_reg <= 1'b1;
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
                best_dist_reg <= '1;
                seg_cnt_reg   <= '0;
                stopped_reg   <= 1'b0;
            end
        end
    end

    pnps_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    pnps_sqrt u_sqrt
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.sqrt_start),
        .metric (cmd.sqrt_metric),
        .rad    (sq_rad),
        .done   (sq_done),
        .root   (sq_root)
    );

    always_comb
    begin
        stat.last      = last_reg;
        stat.stopped   = stopped_reg;
        stat.ctr_full  = seg_cnt_reg >= CTRW'(MAX_SEGMENTS);
        stat.proj      = !num_reg[NUMW-1] && (num_reg != '0)
                         && (num_reg[DENW:0] < (DENW+1)'(den_reg));
        stat.div_done  = div_done;
        stat.sqrt_done = sq_done;
        stat.out_busy  = out_valid_reg && !out_ready;
        stat.mode      = mode_reg;
    end

    assign out_valid       = out_valid_reg;
    assign nearest_segment = out_seg_reg;
    assign near_x          = out_x_reg;
    assign near_y          = out_y_reg;
    assign distance        = out_dist_reg;
    assign overflow        = out_ovf_reg;

    a_emit_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(out_valid_reg && !out_ready))
        else $error("result overwritten while pending");

    a_update_live: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> (!stopped_reg && seg_cnt_reg < CTRW'(MAX_SEGMENTS)))
        else $error("update on stopped or full search");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seg_cnt_reg <= CTRW'(MAX_SEGMENTS + 1))
        else $error("segment count out of range");

    a_quo_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.set_ox || cmd.set_oy) |-> div_done)
        else $error("quotient taken before divider done");

endmodule

>>> rtl/pnps_ctrl.sv
// ----------------------------------------------------------------------------
// pnps_ctrl
// Sequencer: steps the datapath through projection, distance and result.
// ----------------------------------------------------------------------------
module pnps_ctrl
    import pnps_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_IDLE, S_CHECK,
        S_M1, S_M2, S_M3, S_M4, S_M5, S_M6, S_M7, S_M8, S_M9, S_DECIDE,
        S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8,
        S_E0, S_E1, S_E2, S_E3, S_E4, S_E5,
        S_LAST,
        S_Q0, S_Q1, S_Q2, S_Q3, S_Q4, S_Q5, S_Q6, S_Q7, S_Q8, S_Q9, S_Q10,
        S_Q11, S_Q12,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.stopped)
                    state_next = S_LAST;
                else if (stat.ctr_full)
                begin
                    cmd.sat_count = 1'b1;
                    state_next    = S_LAST;
                end
                else
                    state_next = S_M1;
            end
            S_M1: begin cmd.mul_sel = MS_DX_VX; state_next = S_M2; end
            S_M2:
            begin
                cmd.mul_sel = MS_DY_VY;
                cmd.acc_op  = ACC_LOAD;
                state_next  = S_M3;
            end
            S_M3:
            begin
                cmd.mul_sel = MS_VX_VX;
                cmd.acc_op  = ACC_ADD;
                state_next  = S_M4;
            end
            S_M4:
            begin
                cmd.mul_sel   = MS_VY_VY;
                cmd.store_num = 1'b1;
                cmd.acc_op    = ACC_LOAD;
                state_next    = S_M5;
            end
            S_M5:
            begin
                cmd.mul_sel = MS_DX_DX;
                cmd.acc_op  = ACC_ADD;
                state_next  = S_M6;
            end
            S_M6:
            begin
                cmd.mul_sel   = MS_DY_DY;
                cmd.store_den = 1'b1;
                cmd.acc_op    = ACC_LOAD;
                state_next    = S_M7;
            end
            S_M7:
            begin
                cmd.mul_sel = MS_FX_FX;
                cmd.acc_op  = ACC_ADD;
                state_next  = S_M8;
            end
            S_M8:
            begin
                cmd.mul_sel  = MS_FY_FY;
                cmd.store_da = 1'b1;
                cmd.acc_op   = ACC_LOAD;
                state_next   = S_M9;
            end
            S_M9: begin cmd.acc_op = ACC_ADD; state_next = S_DECIDE; end
            S_DECIDE:
            begin
                if (stat.proj)
                    state_next = S_P1;
                else
                begin
                    cmd.endpoint = 1'b1;
                    state_next   = S_E0;
                end
            end
            S_P1: begin cmd.mul_sel = MS_NLO_VX; state_next = S_P2; end
            S_P2:
            begin
                cmd.mul_sel = MS_NHI_VX;
                cmd.acc_op  = ACC_LOAD;
                state_next  = S_P3;
            end
            S_P3:
            begin
                cmd.mul_sel = MS_NLO_VY;
                cmd.acc_op  = ACC_ADD;
                cmd.acc_sh  = SH_33;
                state_next  = S_P4;
            end
            S_P4:
            begin
                cmd.div_start = 1'b1;
                cmd.mul_sel   = MS_NHI_VY;
                cmd.acc_op    = ACC_LOAD;
                state_next    = S_P5;
            end
            S_P5:
            begin
                cmd.acc_op = ACC_ADD;
                cmd.acc_sh = SH_33;
                state_next = S_P6;
            end
            S_P6:
            begin
                if (stat.div_done)
                begin
                    cmd.set_ox = 1'b1;
                    state_next = S_P7;
                end
            end
            S_P7: begin cmd.div_start = 1'b1; state_next = S_P8; end
            S_P8:
            begin
                if (stat.div_done)
                begin
                    cmd.set_oy = 1'b1;
                    state_next = S_E0;
                end
            end
            S_E0: begin cmd.diff_e = 1'b1; state_next = S_E1; end
            S_E1: begin cmd.mul_sel = MS_EX_EX; state_next = S_E2; end
            S_E2:
            begin
                cmd.mul_sel = MS_EY_EY;
                cmd.acc_op  = ACC_LOAD;
                state_next  = S_E3;
            end
            S_E3: begin cmd.acc_op = ACC_ADD; state_next = S_E4; end
            S_E4: begin cmd.sqrt_start = 1'b1; state_next = S_E5; end
            S_E5:
            begin
                if (stat.sqrt_done)
                begin
                    cmd.update = 1'b1;
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                if (!stat.last)
                    state_next = S_IDLE;
                else if (stat.mode)
                    state_next = S_Q0;
                else
                    state_next = S_EMIT;
            end
            S_Q0: begin cmd.diff_best = 1'b1; state_next = S_Q1; end
            S_Q1: begin cmd.mul_sel = MS_EX_LON; state_next = S_Q2; end
            S_Q2:
            begin
                cmd.mul_sel  = MS_EY_LAT;
                cmd.store_mx = 1'b1;
                state_next   = S_Q3;
            end
            S_Q3: begin cmd.store_my = 1'b1; state_next = S_Q4; end
            S_Q4: begin cmd.mul_sel = MS_MXL_MXL; state_next = S_Q5; end
            S_Q5:
            begin
                cmd.mul_sel = MS_MXL_MXH;
                cmd.acc_op  = ACC_LOAD;
                state_next  = S_Q6;
            end
            S_Q6:
            begin
                cmd.mul_sel = MS_MXH_MXH;
                cmd.acc_op  = ACC_ADD;
                cmd.acc_sh  = SH_26;
                state_next  = S_Q7;
            end
            S_Q7:
            begin
                cmd.mul_sel = MS_MYL_MYL;
                cmd.acc_op  = ACC_ADD;
                cmd.acc_sh  = SH_50;
                state_next  = S_Q8;
            end
            S_Q8:
            begin
                cmd.mul_sel = MS_MYL_MYH;
                cmd.acc_op  = ACC_ADD;
                state_next  = S_Q9;
            end
            S_Q9:
            begin
                cmd.mul_sel = MS_MYH_MYH;
                cmd.acc_op  = ACC_ADD;
                cmd.acc_sh  = SH_26;
                state_next  = S_Q10;
            end
            S_Q10:
            begin
                cmd.acc_op = ACC_ADD;
                cmd.acc_sh = SH_50;
                state_next = S_Q11;
            end
            S_Q11:
            begin
                cmd.sqrt_start  = 1'b1;
                cmd.sqrt_metric = 1'b1;
                state_next      = S_Q12;
            end
            S_Q12:
            begin
                if (stat.sqrt_done)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

>>> rtl/polyline_nearest_point_search.sv
// ----------------------------------------------------------------------------
// polyline_nearest_point_search
// Nearest point on a polyline to a query point, one segment per word.
//
//   channel  signals                              direction
//   in       in_valid/in_ready, query, segment    word in
//   out      out_valid/out_ready, result fields   word out
//   cfg      cfg_valid/cfg_ready, index, data     register write
//
// A segment uses the nearer endpoint, or is projected onto the segment with
// two divisions, one per coordinate; either way a square root then gives
// its distance. A segment of a stopped or full search skips the arithmetic.
// A last segment then hands over the result word, in metric mode after a
// second, metric square root.
// Reset needs no clearing pass. A pending result word that is not taken
// holds the block before it writes the next one.
// ----------------------------------------------------------------------------
module polyline_nearest_point_search
    import pnps_pkg::*;
#(
    parameter int MAX_SEGMENTS = 1024
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [31:0]  query_x,
    input  logic signed [31:0]  query_y,
    input  logic signed [31:0]  seg_start_x,
    input  logic signed [31:0]  seg_start_y,
    input  logic signed [31:0]  seg_end_x,
    input  logic signed [31:0]  seg_end_y,
    input  logic                first_segment,
    input  logic                last_segment,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [SEGW-1:0]     nearest_segment,
    output logic signed [31:0]  near_x,
    output logic signed [31:0]  near_y,
    output logic [OUTDW-1:0]    distance,
    output logic                overflow,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_IDXW-1:0] cfg_index,
    input  logic [CFGW-1:0]     cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    pnps_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pnps_datapath #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_dp
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .query_x         (query_x),
        .query_y         (query_y),
        .seg_start_x     (seg_start_x),
        .seg_start_y     (seg_start_y),
        .seg_end_x       (seg_end_x),
        .seg_end_y       (seg_end_y),
        .first_segment   (first_segment),
        .last_segment    (last_segment),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .cmd             (cmd),
        .stat            (stat),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .nearest_segment (nearest_segment),
        .near_x          (near_x),
        .near_y          (near_y),
        .distance        (distance),
        .overflow        (overflow)
    );

endmodule

>>> test/polyline_nearest_point_search_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// polyline_nearest_point_search_tb
// Drives polylines one segment word at a time and checks every result word
// against a local prediction of the nearest point, index and distance, over
// several scale settings, random handshake gaps, a long output stall and a
// polyline long enough to overflow the segment index.
// ----------------------------------------------------------------------------
module polyline_nearest_point_search_tb;
    import pnps_pkg::*;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic [SEGW-1:0]  seg;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [OUTDW-1:0] dist_val;
        logic             ovf;
    } nearest_t;

    localparam logic [CFG_IDXW-1:0] REG_UNUSED = 2'd3;
    localparam int MAX_SEGS = 1024;
    localparam logic [DISTW-1:0] DIST_ONES = '1;
    localparam logic [OUTDW-1:0] OUT_MAX = '1;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic signed [31:0]  query_x = '0;
    logic signed [31:0]  query_y = '0;
    logic signed [31:0]  seg_start_x = '0;
    logic signed [31:0]  seg_start_y = '0;
    logic signed [31:0]  seg_end_x = '0;
    logic signed [31:0]  seg_end_y = '0;
    logic                first_segment = 1'b0;
    logic                last_segment = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [SEGW-1:0]     nearest_segment;
    logic signed [31:0]  near_x;
    logic signed [31:0]  near_y;
    logic [OUTDW-1:0]    distance;
    logic                overflow;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_IDXW-1:0] cfg_index = '0;
    logic [CFGW-1:0]     cfg_data = '0;

    // predictor state
    logic             metric_mode;
    logic [CFGW-1:0]  lon_scale;
    logic [CFGW-1:0]  lat_scale;
    logic [DISTW-1:0] best_dist;
    logic [SEGW-1:0]  best_seg;
    logic signed [31:0] best_x;
    logic signed [31:0] best_y;
    int               seg_count;
    logic             stopped;

    nearest_t nearest_q[$];
    int       faults = 0;
    int       idle_pct = 37;
    int       hold_left = 0;

    always #5 clk = ~clk;

    polyline_nearest_point_search i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .query_x(query_x), .query_y(query_y),
        .seg_start_x(seg_start_x), .seg_start_y(seg_start_y),
        .seg_end_x(seg_end_x), .seg_end_y(seg_end_y),
        .first_segment(first_segment), .last_segment(last_segment),
        .out_valid(out_valid), .out_ready(out_ready),
        .nearest_segment(nearest_segment), .near_x(near_x), .near_y(near_y),
        .distance(distance), .overflow(overflow),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    function automatic logic [63:0] isqrt(logic [127:0] n);
        logic [63:0]  r;
        logic [63:0]  c;
        logic [127:0] cc;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            cc = {64'd0, c} * {64'd0, c};
            if (n >= cc)
                r = c;
        end
        return r;
    endfunction

    function automatic wide_t mag(wide_t v);
        return v < 0 ? -v : v;
    endfunction

    task automatic clear_search();
        best_dist = DIST_ONES;
        seg_count = 0;
        stopped = 1'b0;
    endtask

    task automatic predict_nearest(input logic signed [31:0] qx, qy, ax, ay, bx, by,
                                   input logic first, last);
        wide_t vx, vy, dx, dy, fx, fy, num, den, da, db, ox, oy, ex, ey, qo, mx, my;
        logic [DISTW-1:0] d;
        logic [63:0] met;
        nearest_t r;
        if (first)
            clear_search();
        if (!stopped) begin
            if (seg_count >= MAX_SEGS) begin
                seg_count = MAX_SEGS + 1;
            end else begin
                vx = wide_t'(bx) - wide_t'(ax);
                vy = wide_t'(by) - wide_t'(ay);
                dx = wide_t'(qx) - wide_t'(ax);
                dy = wide_t'(qy) - wide_t'(ay);
                fx = wide_t'(qx) - wide_t'(bx);
                fy = wide_t'(qy) - wide_t'(by);
                num = dx * vx + dy * vy;
                den = vx * vx + vy * vy;
                if (num > 0 && num < den) begin
                    qo = (2 * num * mag(vx) + den) / (2 * den);
                    ox = vx < 0 ? wide_t'(ax) - qo : wide_t'(ax) + qo;
                    qo = (2 * num * mag(vy) + den) / (2 * den);
                    oy = vy < 0 ? wide_t'(ay) - qo : wide_t'(ay) + qo;
                end else begin
                    da = dx * dx + dy * dy;
                    db = fx * fx + fy * fy;
                    ox = da < db ? wide_t'(ax) : wide_t'(bx);
                    oy = da < db ? wide_t'(ay) : wide_t'(by);
                end
                ex = ox - wide_t'(qx);
                ey = oy - wide_t'(qy);
                d = DISTW'(isqrt(ex * ex + ey * ey));
                if (seg_count == 0 || d <= best_dist) begin
                    if (seg_count != 0 && d == best_dist)
                        stopped = 1'b1;
                    best_dist = d;
                    best_seg = SEGW'(seg_count);
                    best_x = ox[31:0];
                    best_y = oy[31:0];
                end else begin
                    stopped = 1'b1;
                end
                seg_count++;
            end
        end
        if (last) begin
            mx = wide_t'(best_x) - wide_t'(qx);
            mx = mx * wide_t'({1'b0, lon_scale});
            my = wide_t'(best_y) - wide_t'(qy);
            my = my * wide_t'({1'b0, lat_scale});
            met = isqrt(mx * mx + my * my);
            r.seg = best_seg;
            r.x = best_x;
            r.y = best_y;
            r.dist_val = metric_mode ? OUTDW'(met > OUT_MAX ? OUT_MAX : met)
                                     : OUTDW'(best_dist);
            r.ovf = seg_count > MAX_SEGS;
            nearest_q.push_back(r);
            clear_search();
        end
    endtask

    task automatic send_segment(input logic signed [31:0] qx, qy, ax, ay, bx, by,
                                input logic first, last);
        if ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        query_x <= qx;
        query_y <= qy;
        seg_start_x <= ax;
        seg_start_y <= ay;
        seg_end_x <= bx;
        seg_end_y <= by;
        first_segment <= first;
        last_segment <= last;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_nearest(qx, qy, ax, ay, bx, by, first, last);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (nearest_q.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDXW-1:0] idx, input logic [CFGW-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_DISTANCE_MODE: metric_mode = val[0];
            REG_LON_SCALE:     lon_scale = val;
            REG_LAT_SCALE:     lat_scale = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_offset(int span);
        case (span)
            0: return $signed($urandom_range(16)) - 8;
            1: return $signed($urandom_range(131072)) - 65536;
            default: return $urandom;
        endcase
    endfunction

    // Chain of segments converging on the query so the search runs deep.
    task automatic send_polyline(input int len, input int span);
        logic signed [31:0] qx, qy, ax, ay, bx, by;
        int sh;
        qx = $urandom;
        qy = $urandom;
        ax = qx + rand_offset(span);
        ay = qy + rand_offset(span);
        for (int k = 0; k < len; k++) begin
            sh = $urandom_range(99) < 80 ? k + 1 : 0;
            bx = qx + (rand_offset(span) >>> sh);
            by = qy + (rand_offset(span) >>> sh);
            if ($urandom_range(99) < 8)
                bx = ax;
            if ($urandom_range(99) < 8) begin
                qx = $urandom;
                qy = $urandom;
            end
            send_segment(qx, qy, ax, ay, bx, by,
                         k == 0 ? $urandom_range(99) >= 8 : $urandom_range(99) < 3,
                         k == len - 1 ? $urandom_range(99) >= 5 : 1'b0);
            if ($urandom_range(99) < 90) begin
                ax = bx;
                ay = by;
            end else begin
                ax = $urandom;
                ay = $urandom;
            end
        end
    endtask

    task automatic test_directed();
        logic signed [31:0] mn, mx;
        mn = 32'sh8000_0000;
        mx = 32'sh7fff_ffff;
        send_segment(mn, mn, mx, mx, mn, mx, 1, 1);
        send_segment(mx, mx, mn, mn, mx, mn, 1, 1);
        send_segment(mx, mn, mn, mx, mx, mn, 1, 1);
        send_segment(0, 10, -10, 0, 10, 0, 1, 1);
        send_segment(3, 7, 0, 0, 10, 3, 1, 1);
        send_segment(-5, 0, 0, 0, 10, 0, 1, 1);
        send_segment(15, 0, 0, 0, 10, 0, 1, 1);
        send_segment(5, 5, 0, 0, 10, 0, 1, 1);
        send_segment(0, 5, 0, 0, 0, 0, 1, 1);
        send_segment(0, 5, -5, 0, 5, 0, 1, 0);
        send_segment(0, 5, 5, 0, -5, 0, 0, 0);
        send_segment(0, 5, 0, 0, 0, 1, 0, 1);
        send_segment(0, 0, 9, 9, 8, 8, 1, 0);
        send_segment(0, 0, 8, 8, 20, 20, 0, 0);
        send_segment(0, 0, 1, 1, 2, 2, 0, 1);
        send_segment(7, 7, 100, 0, 50, 0, 0, 0);
        send_segment(7, 7, 40, 0, 30, 0, 0, 1);
        send_segment(1, 2, 3, 4, 5, 6, 1, 0);
        send_segment(1, 2, 3, 4, 5, 6, 1, 1);
        drain();
    endtask

    task automatic test_config();
        logic [CFGW-1:0] lon_set[6] = '{17'd0, 17'h1ffff, 17'd1, 17'd102000, 17'd0, 17'h1ffff};
        logic [CFGW-1:0] lat_set[6] = '{17'h1ffff, 17'd0, 17'd1, 17'd111000, 17'd0, 17'h1ffff};
        for (int s = 0; s < 6; s++) begin
            write_reg(REG_DISTANCE_MODE, CFGW'(s != 4));
            write_reg(REG_LON_SCALE, lon_set[s]);
            write_reg(REG_LAT_SCALE, lat_set[s]);
            if (s == 5)
                write_reg(REG_UNUSED, CFGW'($urandom));
            for (int p = 0; p < 6; p++)
                send_polyline($urandom_range(1, 4), $urandom_range(2));
            send_segment(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff,
                         32'sh7fff_ffff, 32'sh7fff_ffff, 1, 1);
            drain();
        end
        write_reg(REG_LON_SCALE, CFGW'($urandom));
        write_reg(REG_LAT_SCALE, CFGW'($urandom));
    endtask

    task automatic test_random();
        int sent;
        sent = 0;
        while (sent < 100) begin
            int len;
            len = $urandom_range(99) < 85 ? $urandom_range(1, 6) : $urandom_range(7, 20);
            if (sent > 30 && sent < 70)
                idle_pct = 0;
            else
                idle_pct = 37;
            send_polyline(len, $urandom_range(2));
            sent += len;
        end
        idle_pct = 37;
        drain();
    endtask

    task automatic test_overflow();
        for (int i = 0; i < MAX_SEGS + 6; i++)
            send_segment(0, 0, 5000 - i, 0, 5000 - i, 0, i == 0, i == MAX_SEGS + 5);
        drain();
    endtask

    task automatic test_pressure();
        hold_left = 3000;
        idle_pct = 0;
        for (int i = 0; i < 40; i++)
            send_segment($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 1, 1);
        idle_pct = 37;
        drain();
    endtask

    always @(posedge clk) begin
        nearest_t e;
        if (out_valid && out_ready) begin
            if (nearest_q.size() == 0) begin
                $display("%0t: unexpected word seg=%0d x=%0d y=%0d dist=%0d ovf=%0b", $time,
                         nearest_segment, near_x, near_y, distance, overflow);
                faults++;
            end else begin
                e = nearest_q.pop_front();
                if (e.seg !== nearest_segment) begin
                    $display("%0t: segment exp %0d act %0d", $time, e.seg, nearest_segment);
                    faults++;
                end
                if (e.x !== near_x) begin
                    $display("%0t: near_x exp %0d act %0d", $time, e.x, near_x);
                    faults++;
                end
                if (e.y !== near_y) begin
                    $display("%0t: near_y exp %0d act %0d", $time, e.y, near_y);
                    faults++;
                end
                if (e.dist_val !== distance) begin
                    $display("%0t: distance exp %0d act %0d", $time, e.dist_val, distance);
                    faults++;
                end
                if (e.ovf !== overflow) begin
                    $display("%0t: overflow exp %0b act %0b", $time, e.ovf, overflow);
                    faults++;
                end
            end
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= $urandom_range(99) >= idle_pct;
        end
    end

    initial begin
        #50_000_000;
        $display("[polyline_nearest_point_search] ERROR");
        $finish;
    end

    initial begin
        metric_mode = 1'b0;
        lon_scale = LON_SCALE_RST;
        lat_scale = LAT_SCALE_RST;
        best_seg = '0;
        best_x = '0;
        best_y = '0;
        clear_search();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_config();
        test_random();
        test_pressure();
        test_overflow();
        if (faults == 0)
            $display("[polyline_nearest_point_search] OK");
        else
            $display("[polyline_nearest_point_search] ERROR");
        $finish;
    end

endmodule
